// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// cond must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== design/cau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int DEF_PART_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 8;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NE  = 3'd5,
        OP_NEG = 3'd6
    } op_t;

    // per-word control travelling down the pipe
    typedef struct packed {
        logic valid;
        logic is_div;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
        logic cond;
        logic sat;
        logic dz;
    } ctl_t;

endpackage

`default_nettype wire

// ===== design/cau_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four stages: operand register, products, sums, shift/saturate and
// divide setup.
module cau_front #(
    parameter int PART_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         en,
    input  wire                                         in_valid,
    input  wire  [2:0]                                  req_type,
    input  wire  signed [PART_WIDTH-1:0]                a_re,
    input  wire  signed [PART_WIDTH-1:0]                a_im,
    input  wire  signed [PART_WIDTH-1:0]                b_re,
    input  wire  signed [PART_WIDTH-1:0]                b_im,
    output cau_pkg::ctl_t                               ctl,
    output logic signed [PART_WIDTH-1:0]                res_re,
    output logic signed [PART_WIDTH-1:0]                res_im,
    output logic [2*PART_WIDTH-1:0]                     den,
    output logic [2*PART_WIDTH+FRAC_BITS:0]             rem_re,
    output logic [2*PART_WIDTH+FRAC_BITS:0]             rem_im
);
    import cau_pkg::*;

    localparam int W  = PART_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int RW = 2*W + F + 1;
    localparam int CW = RW + W;

    // stage 1
    logic                v1_reg;
    logic [2:0]          op1_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // stage 2
    logic                  v2_reg, cond2_reg, sat2_reg;
    logic [2:0]            op2_reg;
    logic signed [2*W-1:0] rr2_reg, ii2_reg, ri2_reg, ir2_reg, sr2_reg, si2_reg;
    logic signed [W-1:0]   re2_reg, im2_reg;
    logic signed [W-1:0]   re2_next, im2_next;
    logic                  cond2_next, sat2_next;

    // stage 3
    logic                v3_reg, cond3_reg, sat3_reg;
    logic [2:0]          op3_reg;
    logic signed [2*W:0] mre3_reg, mim3_reg, dre3_reg, dim3_reg;
    logic [2*W-1:0]      den3_reg;
    logic signed [W-1:0] re3_reg, im3_reg;

    // stage 4
    ctl_t                ctl4_reg, ctl4_next;
    logic signed [W-1:0] re4_reg, im4_reg, re4_next, im4_next;
    logic [2*W-1:0]      den4_reg;
    logic [RW-1:0]       rre4_reg, rim4_reg, rre4_next, rim4_next;

    // clamp a W+1 bit value to W bits, flag in the top bit
    function automatic logic [W:0] sat_small(input logic signed [W:0] v);
        logic ovf;
        ovf = v[W] ^ v[W-1];
        sat_small = ovf ? {1'b1, v[W], {(W-1){~v[W]}}} : {1'b0, v[W-1:0]};
    endfunction

    // clamp a 2W+1 bit value to W bits, flag in the top bit
    function automatic logic [W:0] sat_big(input logic signed [2*W:0] v);
        logic ovf;
        ovf = !((&v[2*W:W-1]) || !(|v[2*W:W-1]));
        sat_big = ovf ? {1'b1, v[2*W], {(W-1){~v[2*W]}}} : {1'b0, v[W-1:0]};
    endfunction

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= req_type;
            ar1_reg <= a_re;
            ai1_reg <= a_im;
            br1_reg <= b_re;
            bi1_reg <= b_im;
        end
    end

    // stage 2: cheap ops finish here
    always_comb
    begin
        logic signed [W:0] ar_x, ai_x, br_x, bi_x;
        logic [W:0]        s_re, s_im;
        ar_x = {ar1_reg[W-1], ar1_reg};
        ai_x = {ai1_reg[W-1], ai1_reg};
        br_x = {br1_reg[W-1], br1_reg};
        bi_x = {bi1_reg[W-1], bi1_reg};
        s_re = '0;
        s_im = '0;
        cond2_next = 1'b0;
        unique case (op1_reg)
            OP_ADD:
            begin
                s_re = sat_small(ar_x + br_x);
                s_im = sat_small(ai_x + bi_x);
            end
            OP_SUB:
            begin
                s_re = sat_small(ar_x - br_x);
                s_im = sat_small(ai_x - bi_x);
            end
            OP_NEG:
            begin
                s_re = sat_small(-ar_x);
                s_im = sat_small(-ai_x);
            end
            OP_EQ:  cond2_next = (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
            OP_NE:  cond2_next = (ar1_reg != br1_reg) || (ai1_reg != bi1_reg);
            default:
            begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        re2_next  = s_re[W-1:0];
        im2_next  = s_im[W-1:0];
        sat2_next = s_re[W] | s_im[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg   <= op1_reg;
            rr2_reg   <= ar1_reg * br1_reg;
            ii2_reg   <= ai1_reg * bi1_reg;
            ri2_reg   <= ar1_reg * bi1_reg;
            ir2_reg   <= ai1_reg * br1_reg;
            sr2_reg   <= br1_reg * br1_reg;
            si2_reg   <= bi1_reg * bi1_reg;
            re2_reg   <= re2_next;
            im2_reg   <= im2_next;
            cond2_reg <= cond2_next;
            sat2_reg  <= sat2_next;
        end
    end

    // stage 3: exact sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op3_reg   <= op2_reg;
            mre3_reg  <= {rr2_reg[2*W-1], rr2_reg} - {ii2_reg[2*W-1], ii2_reg};
            mim3_reg  <= {ri2_reg[2*W-1], ri2_reg} + {ir2_reg[2*W-1], ir2_reg};
            dre3_reg  <= {rr2_reg[2*W-1], rr2_reg} + {ii2_reg[2*W-1], ii2_reg};
            dim3_reg  <= {ir2_reg[2*W-1], ir2_reg} - {ri2_reg[2*W-1], ri2_reg};
            den3_reg  <= $unsigned(sr2_reg) + $unsigned(si2_reg);
            re3_reg   <= re2_reg;
            im3_reg   <= im2_reg;
            cond3_reg <= cond2_reg;
            sat3_reg  <= sat2_reg;
        end
    end

    // stage 4: product scaling, divide sign/magnitude and range check
    always_comb
    begin
        logic [W:0]          m_re, m_im;
        logic [2*W:0]        mag_re, mag_im;
        logic [CW-1:0]       den_top;
        logic                is_mul, is_div;
        m_re    = sat_big(mre3_reg >>> F);
        m_im    = sat_big(mim3_reg >>> F);
        mag_re  = dre3_reg[2*W] ? $unsigned(-dre3_reg) : $unsigned(dre3_reg);
        mag_im  = dim3_reg[2*W] ? $unsigned(-dim3_reg) : $unsigned(dim3_reg);
        rre4_next = RW'(mag_re) << F;
        rim4_next = RW'(mag_im) << F;
        den_top   = CW'(den3_reg) << W;
        is_mul  = (op3_reg == OP_MUL);
        is_div  = (op3_reg == OP_DIV);

        ctl4_next.valid  = v3_reg;
        ctl4_next.is_div = is_div;
        ctl4_next.neg_re = dre3_reg[2*W];
        ctl4_next.neg_im = dim3_reg[2*W];
        ctl4_next.ovf_re = CW'(rre4_next) >= den_top;
        ctl4_next.ovf_im = CW'(rim4_next) >= den_top;
        ctl4_next.cond   = cond3_reg;
        ctl4_next.dz     = is_div && (den3_reg == '0);
        ctl4_next.sat    = is_mul ? (m_re[W] | m_im[W]) : sat3_reg;
        re4_next = is_mul ? m_re[W-1:0] : re3_reg;
        im4_next = is_mul ? m_im[W-1:0] : im3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            ctl4_reg <= ctl4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re4_reg  <= re4_next;
            im4_reg  <= im4_next;
            den4_reg <= den3_reg;
            rre4_reg <= rre4_next;
            rim4_reg <= rim4_next;
        end
    end

    assign ctl    = ctl4_reg;
    assign res_re = re4_reg;
    assign res_im = im4_reg;
    assign den    = den4_reg;
    assign rem_re = rre4_reg;
    assign rem_im = rim4_reg;

endmodule

`default_nettype wire

// ===== design/cau_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One restoring-division step for both parts, quotient bit SHIFT.
module cau_div_step #(
    parameter int PART_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int SHIFT      = 0
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  en,
    input  cau_pkg::ctl_t                        ctl_in,
    input  wire  signed [PART_WIDTH-1:0]         res_re_in,
    input  wire  signed [PART_WIDTH-1:0]         res_im_in,
    input  wire  [2*PART_WIDTH-1:0]              den_in,
    input  wire  [2*PART_WIDTH+FRAC_BITS:0]      rem_re_in,
    input  wire  [2*PART_WIDTH+FRAC_BITS:0]      rem_im_in,
    input  wire  [PART_WIDTH-1:0]                quo_re_in,
    input  wire  [PART_WIDTH-1:0]                quo_im_in,
    output cau_pkg::ctl_t                        ctl_out,
    output logic signed [PART_WIDTH-1:0]         res_re_out,
    output logic signed [PART_WIDTH-1:0]         res_im_out,
    output logic [2*PART_WIDTH-1:0]              den_out,
    output logic [2*PART_WIDTH+FRAC_BITS:0]      rem_re_out,
    output logic [2*PART_WIDTH+FRAC_BITS:0]      rem_im_out,
    output logic [PART_WIDTH-1:0]                quo_re_out,
    output logic [PART_WIDTH-1:0]                quo_im_out
);
    import cau_pkg::*;

    localparam int W  = PART_WIDTH;
    localparam int RW = 2*W + FRAC_BITS + 1;
    localparam int CW = RW + W;

    ctl_t                ctl_reg;
    logic signed [W-1:0] re_reg, im_reg;
    logic [2*W-1:0]      den_reg;
    logic [RW-1:0]       rre_reg, rim_reg, rre_next, rim_next;
    logic [W-1:0]        qre_reg, qim_reg, qre_next, qim_next;

    always_comb
    begin
        logic [CW-1:0] dsh;
        logic          ge_re, ge_im;
        dsh   = CW'(den_in) << SHIFT;
        ge_re = CW'(rem_re_in) >= dsh;
        ge_im = CW'(rem_im_in) >= dsh;
        rre_next = ge_re ? RW'(CW'(rem_re_in) - dsh) : rem_re_in;
        rim_next = ge_im ? RW'(CW'(rem_im_in) - dsh) : rem_im_in;
        qre_next = quo_re_in | (W'(ge_re) << SHIFT);
        qim_next = quo_im_in | (W'(ge_im) << SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg  <= res_re_in;
            im_reg  <= res_im_in;
            den_reg <= den_in;
            rre_reg <= rre_next;
            rim_reg <= rim_next;
            qre_reg <= qre_next;
            qim_reg <= qim_next;
        end
    end

    assign ctl_out    = ctl_reg;
    assign res_re_out = re_reg;
    assign res_im_out = im_reg;
    assign den_out    = den_reg;
    assign rem_re_out = rre_reg;
    assign rem_im_out = rim_reg;
    assign quo_re_out = qre_reg;
    assign quo_im_out = qim_reg;

endmodule

`default_nettype wire

// ===== design/complex_arithmetic_unit.sv =====
// Complex-number ALU on a streaming interface.
// Input word: s_tuser carries the opcode (add, sub, mul, div, equal,
// not equal, negate a); s_tdata carries a_re, a_im, b_re, b_im in signed
// fixed point. Output word: m_tdata carries res_re, res_im; m_tuser
// carries cond_flag, saturated and div_by_zero.
// Pipeline: PART_WIDTH + 5 register stages from accept to m_tvalid for every
// opcode; one operand stage, products, sums, scale/setup, one stage per
// quotient bit, then the output register.
// Throughput: one word per cycle; a word enters on every cycle the output
// register is empty or being drained.
// Every stage moves on one common enable, so with a word in the output
// register and m_tready held low, the whole pipe freezes, s_tready drops
// and nothing is lost or repeated. The output word holds steady while stalled.
// Reset clears all valid bits; the pipe is empty and ready afterwards.
// Division by zero magnitude gives zero parts and raises div_by_zero;
// clamped parts raise saturated.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module complex_arithmetic_unit #(
    parameter int PART_WIDTH = cau_pkg::DEF_PART_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::DEF_FRAC_BITS
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    // a_re, a_im, b_re, b_im from bit 0 up, zero padded to bytes
    input  wire  [((4*PART_WIDTH+7)/8)*8-1:0]        s_tdata,
    // req_type
    input  wire  [2:0]                               s_tuser,
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    // res_re, res_im from bit 0 up, zero padded to bytes
    output logic [((2*PART_WIDTH+7)/8)*8-1:0]        m_tdata,
    // cond_flag, saturated, div_by_zero from bit 0 up
    output logic [2:0]                               m_tuser
);
    import cau_pkg::*;

    localparam int W     = PART_WIDTH;
    localparam int RW    = 2*W + FRAC_BITS + 1;
    localparam int OUT_W = ((2*W+7)/8)*8;

    logic en;

    // pipe taps: index 0 is the front end, index W the last divide step
    ctl_t                ctl_s [0:W];
    logic signed [W-1:0] re_s  [0:W];
    logic signed [W-1:0] im_s  [0:W];
    logic [2*W-1:0]      den_s [0:W];
    logic [RW-1:0]       rre_s [0:W];
    logic [RW-1:0]       rim_s [0:W];
    logic [W-1:0]        qre_s [0:W];
    logic [W-1:0]        qim_s [0:W];

    logic                out_valid_reg;
    logic signed [W-1:0] out_re_reg, out_im_reg, out_re_next, out_im_next;
    logic                cond_reg, sat_reg, dz_reg, sat_next;

    // whole pipe advances unless a finished word is held at the output
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    cau_front #(
        .PART_WIDTH (PART_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .req_type (s_tuser),
        .a_re     (s_tdata[W-1:0]),
        .a_im     (s_tdata[2*W-1:W]),
        .b_re     (s_tdata[3*W-1:2*W]),
        .b_im     (s_tdata[4*W-1:3*W]),
        .ctl      (ctl_s[0]),
        .res_re   (re_s[0]),
        .res_im   (im_s[0]),
        .den      (den_s[0]),
        .rem_re   (rre_s[0]),
        .rem_im   (rim_s[0])
    );

    assign qre_s[0] = '0;
    assign qim_s[0] = '0;

    // quotient bits resolved MSB first, one per stage
    for (genvar k = 0; k < W; k++)
    begin : g_div
        cau_div_step #(
            .PART_WIDTH (PART_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .SHIFT      (W - 1 - k)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .ctl_in     (ctl_s[k]),
            .res_re_in  (re_s[k]),
            .res_im_in  (im_s[k]),
            .den_in     (den_s[k]),
            .rem_re_in  (rre_s[k]),
            .rem_im_in  (rim_s[k]),
            .quo_re_in  (qre_s[k]),
            .quo_im_in  (qim_s[k]),
            .ctl_out    (ctl_s[k+1]),
            .res_re_out (re_s[k+1]),
            .res_im_out (im_s[k+1]),
            .den_out    (den_s[k+1]),
            .rem_re_out (rre_s[k+1]),
            .rem_im_out (rim_s[k+1]),
            .quo_re_out (qre_s[k+1]),
            .quo_im_out (qim_s[k+1])
        );
    end

    // signed quotient, clamped; overflow from the range check forces a clamp
    function automatic logic [W:0] quo_sat(input logic [W-1:0] q, input logic neg,
                                           input logic ovf);
        logic signed [W:0] v;
        logic              hi;
        v  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        hi = ovf || (v[W] ^ v[W-1]);
        if (hi)
        begin
            quo_sat = {1'b1, neg, {(W-1){~neg}}};
        end
        else
        begin
            quo_sat = {1'b0, v[W-1:0]};
        end
    endfunction

    always_comb
    begin
        ctl_t       c;
        logic [W:0] d_re, d_im;
        c    = ctl_s[W];
        d_re = quo_sat(qre_s[W], c.neg_re, c.ovf_re);
        d_im = quo_sat(qim_s[W], c.neg_im, c.ovf_im);
        if (c.is_div && !c.dz)
        begin
            out_re_next = d_re[W-1:0];
            out_im_next = d_im[W-1:0];
            sat_next    = d_re[W] | d_im[W];
        end
        else if (c.is_div)
        begin
            out_re_next = '0;
            out_im_next = '0;
            sat_next    = 1'b0;
        end
        else
        begin
            out_re_next = re_s[W];
            out_im_next = im_s[W];
            sat_next    = c.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_s[W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
            cond_reg   <= ctl_s[W].cond;
            sat_reg    <= sat_next;
            dz_reg     <= ctl_s[W].dz;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_im_reg, out_re_reg});
    assign m_tuser  = {dz_reg, sat_reg, cond_reg};

    // divide by zero yields zero parts and no clamp
    `ASSERT_HOLDS(a_dz_zero, clk, rst_n, (out_valid_reg && dz_reg) |-> (out_re_reg == '0 && out_im_reg == '0 && !sat_reg))
    // compares carry zero parts
    `ASSERT_HOLDS(a_cond_zero, clk, rst_n, (out_valid_reg && cond_reg) |-> (out_re_reg == '0 && out_im_reg == '0))
    // flags are mutually exclusive
    `ASSERT_NEVER(a_flag_mix, clk, rst_n, out_valid_reg && ((sat_reg && dz_reg) || (cond_reg && (sat_reg || dz_reg))))

endmodule

`default_nettype wire

// ===== tb/complex_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;

    import cau_pkg::*;

    localparam int PW     = 16;
    localparam int FB     = 8;
    localparam int LAT    = PW + 5;
    localparam int N_RAND = 2000;

    localparam logic signed [15:0] PMAX = 16'sh7fff;
    localparam logic signed [15:0] PMIN = -16'sh8000;

    // one request, one result
    typedef struct {
        logic [2:0]        op;
        logic signed [15:0] ar, ai, br, bi;
    } req_t;

    typedef struct {
        logic signed [15:0] re, im;
        logic cond, sat, dz;
    } res_t;

    // directed row: typed-in expectation only where has_exp is set
    typedef struct {
        req_t req;
        bit   has_exp;
        res_t exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // a_re, a_im, b_re, b_im from bit 0 up
    logic [2:0]  s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // res_re, res_im from bit 0 up
    logic [2:0]  m_tuser;   // cond_flag, saturated, div_by_zero from bit 0 up

    res_t results_due[$];
    int   fail_count;
    int   send_idle_pct;
    int   recv_idle_pct;

    complex_arithmetic_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // clamp a wide signed value into a part, noting any clamp
    function automatic logic signed [15:0] clamp_part(input logic signed [127:0] v,
                                                      inout logic sat);
        if (v > 128'(PMAX))
        begin
            sat = 1'b1;
            return PMAX;
        end
        if (v < 128'(PMIN))
        begin
            sat = 1'b1;
            return PMIN;
        end
        return v[15:0];
    endfunction

    // truncating divide of a scaled numerator
    function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] num,
                                                       input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q   = (mag <<< FB) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic res_t complex_result(input req_t r);
        res_t o;
        logic signed [127:0] ar, ai, br, bi, den;
        ar = r.ar;
        ai = r.ai;
        br = r.br;
        bi = r.bi;
        o  = '{default: '0};
        case (r.op)
            OP_ADD:
            begin
                o.re = clamp_part(ar + br, o.sat);
                o.im = clamp_part(ai + bi, o.sat);
            end
            OP_SUB:
            begin
                o.re = clamp_part(ar - br, o.sat);
                o.im = clamp_part(ai - bi, o.sat);
            end
            OP_MUL:
            begin
                // arithmetic shift floors toward minus infinity
                o.re = clamp_part((ar * br - ai * bi) >>> FB, o.sat);
                o.im = clamp_part((ar * bi + ai * br) >>> FB, o.sat);
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    o.dz = 1'b1;
                else
                begin
                    o.re = clamp_part(quot_trunc(ar * br + ai * bi, den), o.sat);
                    o.im = clamp_part(quot_trunc(ai * br - ar * bi, den), o.sat);
                end
            end
            OP_EQ:  o.cond = (ar == br) && (ai == bi);
            OP_NE:  o.cond = (ar != br) || (ai != bi);
            OP_NEG:
            begin
                o.re = clamp_part(-ar, o.sat);
                o.im = clamp_part(-ai, o.sat);
            end
            default: ;
        endcase
        return o;
    endfunction

    // drive one word and hold until accepted; leaves valid high
    task automatic send_word(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {r.bi, r.br, r.ai, r.ar};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic push_checked(input req_t r);
        results_due.push_back(complex_result(r));
        send_word(r);
    endtask

    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(5))
            0:       return PMAX;
            1:       return PMIN;
            2:       return 16'($signed($urandom_range(0, 1024)) - 512);
            3:       return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic req_t rand_req();
        req_t r;
        r.op = 3'($urandom_range(7));
        r.ar = rand_part();
        r.ai = rand_part();
        r.br = rand_part();
        r.bi = rand_part();
        // half the compares copy a into b, mostly exactly, so both outcomes show
        if ((r.op == OP_EQ || r.op == OP_NE) && $urandom_range(1))
        begin
            r.br = r.ar;
            r.bi = $urandom_range(3) ? r.ai : r.ai ^ 16'(1 << $urandom_range(15));
        end
        if (r.op == OP_DIV && $urandom_range(9) == 0)
        begin
            r.br = '0;
            r.bi = '0;
        end
        return r;
    endfunction

    // receiver: stall at random, check every word against the oldest expectation
    initial
    begin
        res_t exp_res;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_res = results_due.pop_front();
                    if (m_tdata[15:0] !== exp_res.re)
                    begin
                        $error("res_re exp %0d got %0d", exp_res.re, $signed(m_tdata[15:0]));
                        fail_count++;
                    end
                    if (m_tdata[31:16] !== exp_res.im)
                    begin
                        $error("res_im exp %0d got %0d", exp_res.im, $signed(m_tdata[31:16]));
                        fail_count++;
                    end
                    if (m_tuser[0] !== exp_res.cond)
                    begin
                        $error("cond_flag exp %0b got %0b", exp_res.cond, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== exp_res.sat)
                    begin
                        $error("saturated exp %0b got %0b", exp_res.sat, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tuser[2] !== exp_res.dz)
                    begin
                        $error("div_by_zero exp %0b got %0b", exp_res.dz, m_tuser[2]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog: ~2000 words at worst stall rates stay far below this
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        res_t zero_res;
        int   wait_cycles;

        zero_res      = '{default: '0};
        fail_count    = 0;
        send_idle_pct = 11;
        recv_idle_pct = 64;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: every opcode, extremes, saturation, divide by zero
        rows = '{
            '{'{OP_ADD, 16'sd256, 16'sd512, 16'sd256, -16'sd256}, 1'b0, zero_res},
            '{'{OP_ADD, PMAX, PMIN, PMAX, PMIN}, 1'b1, '{PMAX, PMIN, 1'b0, 1'b1, 1'b0}},
            '{'{OP_SUB, PMIN, PMAX, PMAX, PMIN}, 1'b1, '{PMIN, PMAX, 1'b0, 1'b1, 1'b0}},
            '{'{OP_SUB, 16'sd100, -16'sd7, 16'sd3, 16'sd9}, 1'b0, zero_res},
            '{'{OP_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0},
              1'b1, '{16'sd256, 16'sd0, 1'b0, 1'b0, 1'b0}},
            '{'{OP_MUL, PMIN, PMIN, PMIN, PMIN}, 1'b0, zero_res},
            '{'{OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0}, 1'b0, zero_res},
            '{'{OP_MUL, PMAX, PMAX, PMAX, PMIN}, 1'b0, zero_res},
            '{'{OP_DIV, 16'sd512, 16'sd0, 16'sd256, 16'sd0},
              1'b1, '{16'sd512, 16'sd0, 1'b0, 1'b0, 1'b0}},
            '{'{OP_DIV, PMAX, PMIN, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1}},
            '{'{OP_DIV, PMAX, PMAX, 16'sd1, 16'sd0}, 1'b0, zero_res},
            '{'{OP_DIV, -16'sd1, 16'sd3, PMIN, PMAX}, 1'b0, zero_res},
            '{'{OP_DIV, PMIN, PMIN, 16'sd0, 16'sd1}, 1'b0, zero_res},
            '{'{OP_EQ, 16'sd5, -16'sd5, 16'sd5, -16'sd5},
              1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}},
            '{'{OP_EQ, 16'sd5, -16'sd5, 16'sd5, 16'sd5}, 1'b1, zero_res},
            '{'{OP_NE, PMAX, PMIN, PMAX, PMIN}, 1'b1, zero_res},
            '{'{OP_NE, PMAX, PMIN, PMIN, PMIN}, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}},
            '{'{OP_NEG, PMIN, PMAX, 16'sd0, 16'sd0}, 1'b1, '{PMAX, PMIN + 16'sd1, 1'b0, 1'b1, 1'b0}},
            '{'{OP_NEG, 16'sd0, -16'sd1, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd1, 1'b0, 1'b0, 1'b0}},
            // unused opcode gives an all-zero result
            '{'{3'd7, PMAX, PMIN, -16'sd1, 16'sd1}, 1'b1, zero_res}
        };
        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.has_exp)
            begin
                results_due.push_back(rw.exp);
                send_word(rw.req);
            end
            else
                push_checked(rw.req);
        end

        // hold off until the pipe has drained completely
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);

        // random part in three idling phases
        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == N_RAND / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 11;
            end
            else if (n == 2 * N_RAND / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            push_checked(rand_req());
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (results_due.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (2 * LAT) @(negedge clk);

        if (fail_count == 0 && results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
